>>> rtl/cdsu_pkg.sv
// Shared types, codes and widths for the calendar date stepper.
package cdsu_pkg;

    localparam int CDS_COUNT_WIDTH = 16;
    localparam int CDS_MAX_YEAR    = 9999;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_SUB  = 2'd2,
        MODE_CMP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD_DATE = 2'd1,
        STS_CLAMP    = 2'd2
    } t_status;

    localparam logic signed [1:0] ORDER_EQ      = 2'sb00;
    localparam logic signed [1:0] ORDER_LATER   = 2'sb01;
    localparam logic signed [1:0] ORDER_EARLIER = 2'sb11;

    localparam logic [MON_W-1:0]  MONTH_JAN = 4'd1;
    localparam logic [MON_W-1:0]  MONTH_FEB = 4'd2;
    localparam logic [MON_W-1:0]  MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]  DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]  DAY_LAST  = 5'd31;
    localparam logic [YEAR_W-1:0] YEAR_FIRST = 14'd1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  walk_done;
        logic  out_free;
    } t_dp_sts;

endpackage

>>> rtl/calendar_date_stepper_unit.sv
// calendar_date_stepper_unit: top level of the Gregorian date stepper.
// Load and compare: result registered after the prep, exec and finish states.
// Add and subtract: the walk state lies between exec and finish, where the
// datapath walks one month per cycle until the remaining days fit or a range end is hit.
// The next item is accepted once the result is in the output register.
// Synchronous active-low reset: date returns to 01/01/0001, output empty.
module calendar_date_stepper_unit import cdsu_pkg::*; #(
    parameter int COUNT_WIDTH = CDS_COUNT_WIDTH,
    parameter int MAX_YEAR    = CDS_MAX_YEAR
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_mode,
    input  logic [DAY_W-1:0]       i_in_day,
    input  logic [MON_W-1:0]       i_in_month,
    input  logic [YEAR_W-1:0]      i_in_year,
    input  logic [COUNT_WIDTH-1:0] i_day_count,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [DAY_W-1:0]       o_out_day,
    output logic [MON_W-1:0]       o_out_month,
    output logic [YEAR_W-1:0]      o_out_year,
    output logic signed [1:0]      o_order,
    output logic [1:0]             o_status
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    cdsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    cdsu_dp #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .MAX_YEAR    (MAX_YEAR)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_mode),
        .i_in_day    (i_in_day),
        .i_in_month  (i_in_month),
        .i_in_year   (i_in_year),
        .i_day_count (i_day_count),
        .i_out_stall (i_out_stall),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .o_out_day   (o_out_day),
        .o_out_month (o_out_month),
        .o_out_year  (o_out_year),
        .o_order     (o_order),
        .o_status    (o_status)
    );

endmodule

>>> rtl/cdsu_ctrl.sv
// Sequencing state machine for the calendar date stepper.
module cdsu_ctrl import cdsu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_EXEC = 5'b00100,
        ST_WALK = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_PREP;
                end
            end
            // let the leap flag of the given year settle
            ST_PREP: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.mode == MODE_ADD || i_sts.mode == MODE_SUB) begin
                    n_state = ST_WALK;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = ST_FIN;
                end
            end
            // hold until the output register has room
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/cdsu_dp.sv
// Date registers, month walk, load check, compare and output register.
module cdsu_dp import cdsu_pkg::*; #(
    parameter int COUNT_WIDTH = CDS_COUNT_WIDTH,
    parameter int MAX_YEAR    = CDS_MAX_YEAR
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [1:0]              i_mode,
    input  logic [DAY_W-1:0]        i_in_day,
    input  logic [MON_W-1:0]        i_in_month,
    input  logic [YEAR_W-1:0]       i_in_year,
    input  logic [COUNT_WIDTH-1:0]  i_day_count,
    input  logic                    i_out_stall,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic                    o_out_valid,
    output logic [DAY_W-1:0]        o_out_day,
    output logic [MON_W-1:0]        o_out_month,
    output logic [YEAR_W-1:0]       o_out_year,
    output logic signed [1:0]       o_order,
    output logic [1:0]              o_status
);

    localparam int REM_W = (COUNT_WIDTH > DAY_W + 1) ? COUNT_WIDTH : DAY_W + 1;
    localparam logic [YEAR_W-1:0] YEAR_LAST = YEAR_W'(MAX_YEAR);
    localparam int PROD_W = YEAR_W + 13;
    localparam int RECIP_SHIFT = 19;

    // y / 100 as a multiply by 5243 / 2^19, exact for any 14-bit year
    function automatic logic f_leap(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-RECIP_SHIFT-1:0] q;
        logic [YEAR_W-1:0] rem;
        logic cent;
        prod = PROD_W'(y) * PROD_W'(13'd5243);
        q    = prod[PROD_W-1:RECIP_SHIFT];
        rem  = y - (YEAR_W'({q, 6'b0}) + YEAR_W'({q, 5'b0}) + YEAR_W'({q, 2'b0}));
        cent = (rem == '0);
        return ((y[1:0] == 2'b00) && !cent) || (cent && (q[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = '0;
        endcase
        return len;
    endfunction

    // stored date
    logic [DAY_W-1:0]  r_day,   n_day;
    logic [MON_W-1:0]  r_month, n_month;
    logic [YEAR_W-1:0] r_year,  n_year;
    logic              r_leap;

    // item under work
    t_mode             r_mode;
    logic [DAY_W-1:0]  r_in_day;
    logic [MON_W-1:0]  r_in_month;
    logic [YEAR_W-1:0] r_in_year;
    logic              r_in_leap;
    logic [REM_W-1:0]  r_rem,    n_rem;
    logic signed [1:0] r_order,  n_order;
    t_status           r_status, n_status;

    // result register
    logic              r_out_valid;
    logic [DAY_W-1:0]  r_out_day;
    logic [MON_W-1:0]  r_out_month;
    logic [YEAR_W-1:0] r_out_year;
    logic signed [1:0] r_out_order;
    t_status           r_out_status;

    logic [DAY_W-1:0]  cur_len;
    logic [DAY_W-1:0]  prev_len;
    logic [MON_W-1:0]  prev_month;
    logic [DAY_W-1:0]  left;
    logic              add_fits;
    logic              sub_fits;
    logic              at_last;
    logic              at_first;
    logic              load_ok;
    logic              walk_done;
    logic              out_free;

    always_comb begin
        cur_len    = f_month_len(r_month, r_leap);
        prev_month = (r_month == MONTH_JAN) ? MONTH_DEC : r_month - MON_W'(1);
        prev_len   = f_month_len(prev_month, r_leap);
        left       = cur_len - r_day;
        add_fits   = (r_rem <= REM_W'(left));
        sub_fits   = (r_rem < REM_W'(r_day));
        at_last    = (r_month == MONTH_DEC) && (r_year == YEAR_LAST);
        at_first   = (r_month == MONTH_JAN) && (r_year == YEAR_FIRST);
        load_ok    = (r_in_month >= MONTH_JAN) && (r_in_month <= MONTH_DEC) &&
                     (r_in_year >= YEAR_FIRST) && (r_in_year <= YEAR_LAST) &&
                     (r_in_day >= DAY_FIRST) &&
                     (r_in_day <= f_month_len(r_in_month, r_in_leap));
        walk_done  = (r_mode == MODE_ADD) ? (add_fits || at_last) : (sub_fits || at_first);
        out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_sts.mode      = r_mode;
    assign o_sts.walk_done = walk_done;
    assign o_sts.out_free  = out_free;

    always_comb begin
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_rem    = r_rem;
        n_order  = r_order;
        n_status = r_status;
        if (i_cmd.capture) begin
            n_rem = REM_W'(i_day_count);
        end
        if (i_cmd.exec) begin
            n_order  = ORDER_EQ;
            n_status = STS_OK;
            if (r_mode == MODE_LOAD) begin
                if (load_ok) begin
                    n_day   = r_in_day;
                    n_month = r_in_month;
                    n_year  = r_in_year;
                end else begin
                    n_status = STS_BAD_DATE;
                end
            end else if (r_mode == MODE_CMP) begin
                if ({r_year, r_month, r_day} < {r_in_year, r_in_month, r_in_day}) begin
                    n_order = ORDER_EARLIER;
                end else if ({r_year, r_month, r_day} > {r_in_year, r_in_month, r_in_day}) begin
                    n_order = ORDER_LATER;
                end
            end
        end
        if (i_cmd.step) begin
            if (r_mode == MODE_ADD) begin
                if (add_fits) begin
                    n_day = r_day + r_rem[DAY_W-1:0];
                end else if (at_last) begin
                    n_day    = DAY_LAST;
                    n_month  = MONTH_DEC;
                    n_year   = YEAR_LAST;
                    n_status = STS_CLAMP;
                end else begin
                    // advance to the first of the next month
                    n_rem = r_rem - (REM_W'(left) + REM_W'(1));
                    n_day = DAY_FIRST;
                    if (r_month == MONTH_DEC) begin
                        n_month = MONTH_JAN;
                        n_year  = r_year + YEAR_W'(1);
                    end else begin
                        n_month = r_month + MON_W'(1);
                    end
                end
            end else begin
                if (sub_fits) begin
                    n_day = r_day - r_rem[DAY_W-1:0];
                end else if (at_first) begin
                    n_day    = DAY_FIRST;
                    n_month  = MONTH_JAN;
                    n_year   = YEAR_FIRST;
                    n_status = STS_CLAMP;
                end else begin
                    // drop back to the last day of the previous month
                    n_rem   = r_rem - REM_W'(r_day);
                    n_month = prev_month;
                    n_day   = prev_len;
                    if (r_month == MONTH_JAN) begin
                        n_year = r_year - YEAR_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day       <= DAY_FIRST;
            r_month     <= MONTH_JAN;
            r_year      <= YEAR_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
            r_out_valid <= i_cmd.out_load || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_leap    <= f_leap(r_year);
        r_in_leap <= f_leap(r_in_year);
        r_rem     <= n_rem;
        r_order   <= n_order;
        r_status  <= n_status;
        if (i_cmd.capture) begin
            r_mode     <= t_mode'(i_mode);
            r_in_day   <= i_in_day;
            r_in_month <= i_in_month;
            r_in_year  <= i_in_year;
        end
        if (i_cmd.out_load) begin
            r_out_day    <= r_day;
            r_out_month  <= r_month;
            r_out_year   <= r_year;
            r_out_order  <= r_order;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_day   = r_out_day;
    assign o_out_month = r_out_month;
    assign o_out_year  = r_out_year;
    assign o_order     = r_out_order;
    assign o_status    = r_out_status;

    a_rem_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && !walk_done |=> r_rem < $past(r_rem))
        else $error("month walk did not consume days");

    a_bad_load_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (r_mode == MODE_LOAD) && !load_ok |=> $stable({r_day, r_month, r_year}))
        else $error("rejected load changed the stored date");

    a_clamp_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == STS_CLAMP) |->
            ((r_out_day == DAY_LAST) && (r_out_month == MONTH_DEC) &&
             (r_out_year == YEAR_LAST)) ||
            ((r_out_day == DAY_FIRST) && (r_out_month == MONTH_JAN) &&
             (r_out_year == YEAR_FIRST)))
        else $error("clamped result is not an end of the year range");

    a_order_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_order != ORDER_EQ) |-> (r_out_status == STS_OK))
        else $error("nonzero order with error status");

endmodule

>>> tb/calendar_date_stepper_unit_checker.sv
// Date stepper checker: tracks the stored date, predicts each result and compares it.
module calendar_date_stepper_unit_checker import cdsu_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [1:0]                 i_mode,
    input  logic [DAY_W-1:0]           i_in_day,
    input  logic [MON_W-1:0]           i_in_month,
    input  logic [YEAR_W-1:0]          i_in_year,
    input  logic [CDS_COUNT_WIDTH-1:0] i_day_count,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [DAY_W-1:0]           i_out_day,
    input  logic [MON_W-1:0]           i_out_month,
    input  logic [YEAR_W-1:0]          i_out_year,
    input  logic signed [1:0]          i_order,
    input  logic [1:0]                 i_status,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 60;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [1:0]        order;
        t_status           status;
    } t_date_result;

    int unsigned    date_day;
    int unsigned    date_month;
    int unsigned    date_year;
    t_date_result   date_results_q[$];
    t_date_result   want;

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // days from 01/01/0001 to 01/01 of year y
    function automatic int unsigned year_start(input int unsigned y);
        int unsigned p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned n;
        n = year_start(y);
        for (int unsigned k = 1; k < m; k++) begin
            n += days_in_month(k, y);
        end
        return n + d - 1;
    endfunction

    function automatic void set_from_day_number(input int unsigned n);
        int unsigned y;
        int unsigned m;
        int unsigned r;
        // n/366 never overshoots the year; walk forward from there
        y = n / 366 + 1;
        while (year_start(y + 1) <= n) begin
            y++;
        end
        r = n - year_start(y);
        m = MONTH_JAN;
        while (m < MONTH_DEC && r >= days_in_month(m, y)) begin
            r -= days_in_month(m, y);
            m++;
        end
        date_day   = r + 1;
        date_month = m;
        date_year  = y;
    endfunction

    function automatic void clamp_to(input int unsigned d, input int unsigned m,
                                     input int unsigned y);
        date_day   = d;
        date_month = m;
        date_year  = y;
    endfunction

    function automatic t_date_result step_date(input t_mode mode, input int unsigned d,
                                               input int unsigned m, input int unsigned y,
                                               input int unsigned cnt);
        t_date_result    res;
        int unsigned     now;
        int unsigned     last;
        longint unsigned held;
        longint unsigned given;
        res.order  = ORDER_EQ;
        res.status = STS_OK;
        case (mode)
            MODE_LOAD: begin
                if (m >= MONTH_JAN && m <= MONTH_DEC && y >= YEAR_FIRST && y <= CDS_MAX_YEAR &&
                    d >= DAY_FIRST && d <= days_in_month(m, y)) begin
                    date_day   = d;
                    date_month = m;
                    date_year  = y;
                end else begin
                    res.status = STS_BAD_DATE;
                end
            end
            MODE_ADD: begin
                now  = day_number(date_day, date_month, date_year);
                last = year_start(CDS_MAX_YEAR + 1) - 1;
                if (cnt > last - now) begin
                    clamp_to(DAY_LAST, MONTH_DEC, CDS_MAX_YEAR);
                    res.status = STS_CLAMP;
                end else begin
                    set_from_day_number(now + cnt);
                end
            end
            MODE_SUB: begin
                now = day_number(date_day, date_month, date_year);
                if (cnt > now) begin
                    clamp_to(DAY_FIRST, MONTH_JAN, YEAR_FIRST);
                    res.status = STS_CLAMP;
                end else begin
                    set_from_day_number(now - cnt);
                end
            end
            default: begin
                // raw lexicographic order, no validation of the given date
                held  = longint'(date_year) * 10000 + date_month * 100 + date_day;
                given = longint'(y) * 10000 + m * 100 + d;
                if (held < given) begin
                    res.order = ORDER_EARLIER;
                end else if (held > given) begin
                    res.order = ORDER_LATER;
                end
            end
        endcase
        res.day   = DAY_W'(date_day);
        res.month = MON_W'(date_month);
        res.year  = YEAR_W'(date_year);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            date_day   = DAY_FIRST;
            date_month = MONTH_JAN;
            date_year  = YEAR_FIRST;
            date_results_q.delete();
            o_fail_count = 0;
            o_pending   <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                date_results_q.push_back(step_date(t_mode'(i_mode), i_in_day, i_in_month,
                                                   i_in_year, i_day_count));
            end
            if (i_out_valid && !i_out_stall) begin
                if (date_results_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with no item pending",
                                              i_out_day, i_out_month, i_out_year));
                end else begin
                    want = date_results_q.pop_front();
                    if (i_out_day !== want.day) begin
                        report_mismatch($sformatf("day %0d, expected %0d",
                                                  i_out_day, want.day));
                    end
                    if (i_out_month !== want.month) begin
                        report_mismatch($sformatf("month %0d, expected %0d",
                                                  i_out_month, want.month));
                    end
                    if (i_out_year !== want.year) begin
                        report_mismatch($sformatf("year %0d, expected %0d",
                                                  i_out_year, want.year));
                    end
                    if (i_order !== want.order) begin
                        report_mismatch($sformatf("order %0d, expected %0d",
                                                  i_order, $signed(want.order)));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    end
                end
            end
            o_pending <= date_results_q.size();
        end
    end

endmodule

>>> tb/calendar_date_stepper_unit_tb.sv
// Date stepper testbench top: clock, reset, stimulus with random idling, and the verdict.
module calendar_date_stepper_unit_tb;
    import cdsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int TOTAL_ITEMS  = 250;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic [1:0]                 i_mode      = MODE_LOAD;
    logic [DAY_W-1:0]           i_in_day    = DAY_FIRST;
    logic [MON_W-1:0]           i_in_month  = MONTH_JAN;
    logic [YEAR_W-1:0]          i_in_year   = YEAR_FIRST;
    logic [CDS_COUNT_WIDTH-1:0] i_day_count = '0;
    logic                       i_out_stall = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [DAY_W-1:0]           o_out_day;
    logic [MON_W-1:0]           o_out_month;
    logic [YEAR_W-1:0]          o_out_year;
    logic signed [1:0]          o_order;
    logic [1:0]                 o_status;

    int fail_count;
    int pending;
    int cycle_cnt  = 0;
    int n_sent     = 0;
    int stall_hold = 0;
    bit calm       = 1'b0;

    calendar_date_stepper_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_in_day    (i_in_day),
        .i_in_month  (i_in_month),
        .i_in_year   (i_in_year),
        .i_day_count (i_day_count),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_day   (o_out_day),
        .o_out_month (o_out_month),
        .o_out_year  (o_out_year),
        .o_order     (o_order),
        .o_status    (o_status)
    );

    calendar_date_stepper_unit_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_in_day     (i_in_day),
        .i_in_month   (i_in_month),
        .i_in_year    (i_in_year),
        .i_day_count  (i_day_count),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_day    (o_out_day),
        .i_out_month  (o_out_month),
        .i_out_year   (o_out_year),
        .i_order      (o_order),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("** calendar_date_stepper_unit: FAILED **");
        $finish;
    end

    // mostly short gaps, now and then a long one; none in calm stretches
    function automatic int pick_idle();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return 0;
        end
        if (r < 18) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CDS_COUNT_WIDTH-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return $urandom_range(0, 40);
        end
        if (r < 8) begin
            return $urandom_range(0, 2000);
        end
        if (r < 9) begin
            return $urandom_range(0, 65535);
        end
        return 65535 - $urandom_range(0, 3);
    endfunction

    function automatic logic [YEAR_W-1:0] pick_year();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return $urandom_range(1, 4);
        end
        if (r == 1) begin
            return $urandom_range(CDS_MAX_YEAR - 3, CDS_MAX_YEAR);
        end
        return $urandom_range(1, CDS_MAX_YEAR);
    endfunction

    always @(posedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
            stall_hold  <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
            stall_hold  <= pick_idle();
        end
    end

    // valid stays high from one item to the next when there is no gap
    task automatic send_item(input t_mode mode, input logic [DAY_W-1:0] d,
                             input logic [MON_W-1:0] m, input logic [YEAR_W-1:0] y,
                             input logic [CDS_COUNT_WIDTH-1:0] cnt);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_in_day    <= d;
        i_in_month  <= m;
        i_in_year   <= y;
        i_day_count <= cnt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
    endtask

    initial begin
        int                         pat;
        int                         nops;
        logic [DAY_W-1:0]           ld_day;
        logic [MON_W-1:0]           ld_month;
        logic [YEAR_W-1:0]          ld_year;
        logic [CDS_COUNT_WIDTH-1:0] cnt;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset date, range ends, leap rules, invalid loads, odd compares
        send_item(MODE_CMP,  1, 1, 1, '0);
        send_item(MODE_SUB,  0, 0, 0, 1);
        send_item(MODE_ADD,  0, 0, 0, 0);
        send_item(MODE_ADD,  0, 0, 0, 16'hFFFF);
        send_item(MODE_SUB,  0, 0, 0, 16'hFFFF);
        send_item(MODE_LOAD, 29, 2, 2000, '0);
        send_item(MODE_LOAD, 29, 2, 1900, '0);
        send_item(MODE_LOAD, 29, 2, 2023, '0);
        send_item(MODE_LOAD, 29, 2, 2024, '0);
        send_item(MODE_LOAD, 0, 5, 2020, '0);
        send_item(MODE_LOAD, 31, 4, 2020, '0);
        send_item(MODE_LOAD, 1, 13, 2020, '0);
        send_item(MODE_LOAD, 1, 0, 2020, '0);
        send_item(MODE_LOAD, 1, 1, 0, '0);
        send_item(MODE_LOAD, 1, 1, 10000, '0);
        send_item(MODE_LOAD, 31, 15, 16383, '1);
        send_item(MODE_LOAD, 28, 2, 2100, '0);
        send_item(MODE_ADD,  0, 0, 0, 1);
        send_item(MODE_LOAD, 1, 3, 2000, '0);
        send_item(MODE_SUB,  0, 0, 0, 1);
        send_item(MODE_CMP,  31, 15, 16383, '0);
        send_item(MODE_CMP,  0, 0, 0, '0);
        send_item(MODE_LOAD, 31, 12, CDS_MAX_YEAR, '0);
        send_item(MODE_ADD,  0, 0, 0, 1);
        send_item(MODE_SUB,  0, 0, 0, 16'hFFFF);

        // random: mostly load-then-walk sequences, some raw noise
        while (n_sent < TOTAL_ITEMS) begin
            calm = ($urandom_range(0, 5) == 0);
            pat  = $urandom_range(0, 9);
            if (pat == 0) begin
                send_item(t_mode'($urandom_range(0, 3)), $urandom_range(0, 31),
                          $urandom_range(0, 15), $urandom_range(0, 16383),
                          $urandom_range(0, 65535));
            end else begin
                ld_day   = ($urandom_range(0, 7) == 0) ? $urandom_range(29, 31)
                                                       : $urandom_range(1, 28);
                ld_month = $urandom_range(1, 12);
                ld_year  = pick_year();
                send_item(MODE_LOAD, ld_day, ld_month, ld_year, $urandom_range(0, 65535));
                if (pat <= 2) begin
                    // there and back again: should compare equal unless clamped or the load was rejected
                    cnt = pick_count();
                    send_item(MODE_ADD, $urandom_range(0, 31), $urandom_range(0, 15),
                              $urandom_range(0, 16383), cnt);
                    send_item(MODE_SUB, $urandom_range(0, 31), $urandom_range(0, 15),
                              $urandom_range(0, 16383), cnt);
                    send_item(MODE_CMP, ld_day, ld_month, ld_year, $urandom_range(0, 65535));
                end else begin
                    nops = $urandom_range(1, 4);
                    repeat (nops) begin
                        case ($urandom_range(0, 2))
                            0: send_item(MODE_ADD, $urandom_range(0, 31), $urandom_range(0, 15),
                                         $urandom_range(0, 16383), pick_count());
                            1: send_item(MODE_SUB, $urandom_range(0, 31), $urandom_range(0, 15),
                                         $urandom_range(0, 16383), pick_count());
                            default: begin
                                if ($urandom_range(0, 1) == 0) begin
                                    send_item(MODE_CMP, ld_day, ld_month, ld_year,
                                              $urandom_range(0, 65535));
                                end else begin
                                    send_item(MODE_CMP, $urandom_range(1, 31),
                                              $urandom_range(1, 12), pick_year(),
                                              $urandom_range(0, 65535));
                                end
                            end
                        endcase
                    end
                end
            end
        end

        i_in_valid <= 1'b0;
        calm = 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** calendar_date_stepper_unit: PASSED **");
        end else begin
            $display("** calendar_date_stepper_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/cdsu_pkg.sv
rtl/cdsu_ctrl.sv
rtl/cdsu_dp.sv
rtl/calendar_date_stepper_unit.sv
tb/calendar_date_stepper_unit_checker.sv
tb/calendar_date_stepper_unit_tb.sv
